FILE: sv/nnza_pkg.sv
// ----------------------------------------------------------------------------
// nnza_pkg
// Types, constants and helper functions for the nearest-neighbor zoom
// addresser: payload structs, register indexes and one divider step.
// ----------------------------------------------------------------------------
package nnza_pkg;

    // Default frame sizes
    localparam int DEF_SRC_WIDTH  = 1024;
    localparam int DEF_SRC_HEIGHT = 1024;
    localparam int DEF_DST_WIDTH  = 1024;
    localparam int DEF_DST_HEIGHT = 1024;

    // Field widths
    localparam int CFG_IDX_W  = 4;               // room for indexes past the last register
    localparam int CFG_DATA_W = 12;
    localparam int OFS_W      = 12;              // offset_x / offset_y
    localparam int ADDR_W     = 20;              // frame byte offsets
    localparam int SPAN_W     = 14;              // right - left + 1, signed
    localparam int POS_W      = 14;              // absolute positions, signed
    localparam int DIV_W      = 13;              // positive span, up to 4096
    localparam int QUO_W      = 12;              // quotient < source span
    localparam int NUM_W      = 2 * QUO_W;       // dividend < 2^24
    localparam int PIX_W      = 11;              // in-frame coordinate, frames up to 2048
    localparam int FRAME_W    = 12;              // frame size value, up to 2048
    localparam int LIN_W      = PIX_W + FRAME_W; // row * width + column before wrap

    // One quotient bit per divider stage
    localparam int DIV_STAGES = QUO_W;
    // Sampled edges from an accepted start to its done strobe
    localparam int ZM_LATENCY = DIV_STAGES + 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LEFT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_TOP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_RIGHT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BOTTOM = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_LEFT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_TOP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_RIGHT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BOTTOM = 4'd7;

    typedef struct packed {
        logic [OFS_W-1:0] offset_x;
        logic [OFS_W-1:0] offset_y;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_offset;
        logic [ADDR_W-1:0] dst_offset;
        logic              write_enable;
    } out_item_t;

    // Per-axis divider state
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] numlo;
        logic [QUO_W-1:0] quo;
    } axis_t;

    // Side data carried past the divider
    typedef struct packed {
        logic                    ok;
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
    } side_t;

    function automatic logic signed [SPAN_W-1:0] sext_cfg(input logic [CFG_DATA_W-1:0] v);
        return {{(SPAN_W-CFG_DATA_W){v[CFG_DATA_W-1]}}, v};
    endfunction

    // Restoring division, one quotient bit
    function automatic axis_t div_step(input axis_t a, input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic [DIV_W:0] diff;
        axis_t          r;
        t       = {a.rem, a.numlo[QUO_W-1]};
        diff    = t - {1'b0, d};
        r.numlo = {a.numlo[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem = diff[DIV_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[DIV_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: sv/nearest_neighbor_zoom_addresser_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_zoom_addresser_top
// Maps a destination pixel offset to source and destination frame byte
// offsets by nearest-neighbor scaling, with a write-enable for the copy.
// ----------------------------------------------------------------------------
// Order: stages 1 and 2, the divider stages, stage 3, then stage 4 drives done.
// Throughput: one item per cycle; busy stays low, each divider stage makes
//   one quotient bit per axis, so twelve stages set the depth.
// Reset (rst_n low, async): pipeline valid bits and corner registers clear
//   to 0, span registers to 1; other datapath registers are not reset.
// Results cannot be stalled: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module nearest_neighbor_zoom_addresser_top
    import nnza_pkg::*;
#(
    parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = DEF_SRC_HEIGHT,
    parameter int DST_WIDTH  = DEF_DST_WIDTH,
    parameter int DST_HEIGHT = DEF_DST_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  done,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Frame limits as signed positions for the bounds checks
    localparam logic signed [POS_W-1:0] SRC_W_LIM = POS_W'(SRC_WIDTH);
    localparam logic signed [POS_W-1:0] SRC_H_LIM = POS_W'(SRC_HEIGHT);
    localparam logic signed [POS_W-1:0] DST_W_LIM = POS_W'(DST_WIDTH);
    localparam logic signed [POS_W-1:0] DST_H_LIM = POS_W'(DST_HEIGHT);
    localparam logic signed [SPAN_W-1:0] SPAN_ONE = SPAN_W'(1);

    // The pipeline never holds off: a new item every cycle. Register writes
    // always complete in one transfer.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] src_left_reg, src_top_reg, src_right_reg, src_bottom_reg;
    logic [CFG_DATA_W-1:0] dst_left_reg, dst_top_reg, dst_right_reg, dst_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_left_reg   <= '0;
            src_top_reg    <= '0;
            src_right_reg  <= '0;
            src_bottom_reg <= '0;
            dst_left_reg   <= '0;
            dst_top_reg    <= '0;
            dst_right_reg  <= '0;
            dst_bottom_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SRC_LEFT:   src_left_reg   <= cfg_data;
                REG_SRC_TOP:    src_top_reg    <= cfg_data;
                REG_SRC_RIGHT:  src_right_reg  <= cfg_data;
                REG_SRC_BOTTOM: src_bottom_reg <= cfg_data;
                REG_DST_LEFT:   dst_left_reg   <= cfg_data;
                REG_DST_TOP:    dst_top_reg    <= cfg_data;
                REG_DST_RIGHT:  dst_right_reg  <= cfg_data;
                REG_DST_BOTTOM: dst_bottom_reg <= cfg_data;
                default:        ; // indexes past the last register are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Spans, refreshed every cycle. The user must change registers
    // only while the pipeline is empty; nothing enforces it. Spans
    // are first used in stage 2, so a write before start is seen.
    // ------------------------------------------------------------------
    logic signed [SPAN_W-1:0] sspan_x_reg, sspan_y_reg, dspan_x_reg, dspan_y_reg;
    logic signed [SPAN_W-1:0] sspan_x_next, sspan_y_next, dspan_x_next, dspan_y_next;

    always_comb
    begin
        sspan_x_next = sext_cfg(src_right_reg)  - sext_cfg(src_left_reg) + SPAN_ONE;
        sspan_y_next = sext_cfg(src_bottom_reg) - sext_cfg(src_top_reg)  + SPAN_ONE;
        dspan_x_next = sext_cfg(dst_right_reg)  - sext_cfg(dst_left_reg) + SPAN_ONE;
        dspan_y_next = sext_cfg(dst_bottom_reg) - sext_cfg(dst_top_reg)  + SPAN_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sspan_x_reg <= SPAN_ONE;
            sspan_y_reg <= SPAN_ONE;
            dspan_x_reg <= SPAN_ONE;
            dspan_y_reg <= SPAN_ONE;
        end
        else
        begin
            sspan_x_reg <= sspan_x_next;
            sspan_y_reg <= sspan_y_next;
            dspan_x_reg <= dspan_x_next;
            dspan_y_reg <= dspan_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input capture
    // ------------------------------------------------------------------
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= item;
    end

    // ------------------------------------------------------------------
    // Stage 2: range checks, dividends, absolute destination position
    // ------------------------------------------------------------------
    logic                     spans_pos;
    logic                     in_rect;
    logic signed [SPAN_W-1:0] ox_s, oy_s;
    logic [OFS_W+DIV_W-1:0]   prod_x, prod_y;
    side_t                    s2_side_next;

    always_comb
    begin
        ox_s      = $signed({{(SPAN_W-OFS_W){1'b0}}, s1_item_reg.offset_x});
        oy_s      = $signed({{(SPAN_W-OFS_W){1'b0}}, s1_item_reg.offset_y});
        spans_pos = (sspan_x_reg > 0) && (sspan_y_reg > 0)
                 && (dspan_x_reg > 0) && (dspan_y_reg > 0);
        in_rect   = (ox_s < dspan_x_reg) && (oy_s < dspan_y_reg);
        // ox < dspan keeps the product below 2^24 and the quotient below 2^12
        prod_x    = s1_item_reg.offset_x * sspan_x_reg[DIV_W-1:0];
        prod_y    = s1_item_reg.offset_y * sspan_y_reg[DIV_W-1:0];
        s2_side_next.ok = spans_pos && in_rect;
        s2_side_next.ax = ox_s + sext_cfg(dst_left_reg);
        s2_side_next.ay = oy_s + sext_cfg(dst_top_reg);
    end

    logic             s2_valid_reg;
    side_t            s2_side_reg;
    logic [NUM_W-1:0] s2_num_x_reg, s2_num_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg  <= s2_side_next;
        s2_num_x_reg <= prod_x[NUM_W-1:0];
        s2_num_y_reg <= prod_y[NUM_W-1:0];
    end

    // ------------------------------------------------------------------
    // Divider: DIV_STAGES restoring stages per axis. The high half of the
    // dividend starts as the remainder since it is already below the span.
    // ------------------------------------------------------------------
    axis_t div_init_x, div_init_y;

    always_comb
    begin
        div_init_x.rem   = {1'b0, s2_num_x_reg[NUM_W-1:QUO_W]};
        div_init_x.numlo = s2_num_x_reg[QUO_W-1:0];
        div_init_x.quo   = '0;
        div_init_y.rem   = {1'b0, s2_num_y_reg[NUM_W-1:QUO_W]};
        div_init_y.numlo = s2_num_y_reg[QUO_W-1:0];
        div_init_y.quo   = '0;
    end

    logic  dv_valid_reg [DIV_STAGES];
    axis_t dx_reg       [DIV_STAGES];
    axis_t dy_reg       [DIV_STAGES];
    side_t dside_reg    [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            logic  valid_in;
            axis_t x_in, y_in;
            side_t side_in;

            if (k == 0)
            begin : g_first
                assign valid_in = s2_valid_reg;
                assign x_in     = div_init_x;
                assign y_in     = div_init_y;
                assign side_in  = s2_side_reg;
            end
            else
            begin : g_next
                assign valid_in = dv_valid_reg[k-1];
                assign x_in     = dx_reg[k-1];
                assign y_in     = dy_reg[k-1];
                assign side_in  = dside_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_valid_reg[k] <= 1'b0;
                else
                    dv_valid_reg[k] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                dx_reg[k]    <= div_step(x_in, dspan_x_reg[DIV_W-1:0]);
                dy_reg[k]    <= div_step(y_in, dspan_y_reg[DIV_W-1:0]);
                dside_reg[k] <= side_in;
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 3: source position and frame bounds
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] sx, sy;
    side_t                   last_side;
    logic                    s3_ok_next;

    always_comb
    begin
        last_side  = dside_reg[DIV_STAGES-1];
        sx = $signed({{(POS_W-QUO_W){1'b0}}, dx_reg[DIV_STAGES-1].quo}) + sext_cfg(src_left_reg);
        sy = $signed({{(POS_W-QUO_W){1'b0}}, dy_reg[DIV_STAGES-1].quo}) + sext_cfg(src_top_reg);
        s3_ok_next = last_side.ok
                  && (sx >= 0) && (sx < SRC_W_LIM)
                  && (sy >= 0) && (sy < SRC_H_LIM)
                  && (last_side.ax >= 0) && (last_side.ax < DST_W_LIM)
                  && (last_side.ay >= 0) && (last_side.ay < DST_H_LIM);
    end

    logic             s3_valid_reg;
    logic             s3_ok_reg;
    logic [PIX_W-1:0] s3_sx_reg, s3_sy_reg, s3_ax_reg, s3_ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        s3_ok_reg <= s3_ok_next;
        s3_sx_reg <= sx[PIX_W-1:0];
        s3_sy_reg <= sy[PIX_W-1:0];
        s3_ax_reg <= last_side.ax[PIX_W-1:0];
        s3_ay_reg <= last_side.ay[PIX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 4: linear offsets (row * width + column), wrapped to 20 bits;
    // a skipped pixel reports zero offsets.
    // ------------------------------------------------------------------
    logic [LIN_W-1:0] src_lin, dst_lin;
    out_item_t        result_next;

    always_comb
    begin
        src_lin = LIN_W'(s3_sy_reg) * LIN_W'(SRC_WIDTH) + LIN_W'(s3_sx_reg);
        dst_lin = LIN_W'(s3_ay_reg) * LIN_W'(DST_WIDTH) + LIN_W'(s3_ax_reg);
        result_next.write_enable = s3_ok_reg;
        result_next.src_offset   = s3_ok_reg ? src_lin[ADDR_W-1:0] : '0;
        result_next.dst_offset   = s3_ok_reg ? dst_lin[ADDR_W-1:0] : '0;
    end

    logic      done_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/nnza_chk.sv
// ----------------------------------------------------------------------------
// nnza_chk
// Port-level checks for the zoom addresser, bound to the top level.
// ----------------------------------------------------------------------------
module nnza_chk
    import nnza_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_item_t result
);

    // Every taken item yields a strobe after the fixed pipeline depth
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##ZM_LATENCY done)
        else $error("taken item produced no done strobe");

    // No strobe without a matching transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ZM_LATENCY))
        else $error("done strobe without a taken item");

    // Skipped pixels carry zero offsets
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.write_enable |-> result.src_offset == '0 && result.dst_offset == '0)
        else $error("skipped pixel has nonzero offsets");

endmodule

bind nearest_neighbor_zoom_addresser_top nnza_chk u_nnza_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_neighbor_zoom_addresser_top. A short
// directed table covers reset values, span and frame edge cases and unknown
// register writes. Random phases follow, each with a new rectangle setting
// and a burst of pixel offsets. Every result is checked field by field
// against a hand-typed value or an in-bench scaling predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import nnza_pkg::*;

    localparam int NUM_ZOOM_REGS = 8;
    localparam int RANDOM_PIXELS = 1300;
    localparam int STALL_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int MAX_GAP       = 12;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // One row of the directed table: either a register write or a pixel.
    // Pixel rows with literal set carry their result typed in by hand.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        in_item_t              px;
        logic                  literal;
        out_item_t             want;
    } stim_row_t;

    localparam out_item_t SKIPPED = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_item_t              item;
    logic                  done;
    out_item_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the rectangle corners, updated on each register transfer
    logic signed [CFG_DATA_W-1:0] zoom_reg [NUM_ZOOM_REGS];

    out_item_t expected_pixels [$];
    stim_row_t directed_rows [$];
    int        mismatches  = 0;
    int        stall_cycles = 0;
    bit        idle_on;

    nearest_neighbor_zoom_addresser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: nearest-neighbor mapping of one destination offset.
    // Any non-positive span, an offset past the destination span, or a
    // source/destination position off its frame gives an all-zero result.
    // ------------------------------------------------------------------------
    function automatic out_item_t map_pixel(input in_item_t px);
        int        ox, oy;
        int        span_sx, span_sy, span_dx, span_dy;
        int        sx, sy, ax, ay;
        int        lin;
        out_item_t r;
        r       = SKIPPED;
        ox      = int'(px.offset_x);
        oy      = int'(px.offset_y);
        span_sx = int'(zoom_reg[REG_SRC_RIGHT]) - int'(zoom_reg[REG_SRC_LEFT]) + 1;
        span_sy = int'(zoom_reg[REG_SRC_BOTTOM]) - int'(zoom_reg[REG_SRC_TOP]) + 1;
        span_dx = int'(zoom_reg[REG_DST_RIGHT]) - int'(zoom_reg[REG_DST_LEFT]) + 1;
        span_dy = int'(zoom_reg[REG_DST_BOTTOM]) - int'(zoom_reg[REG_DST_TOP]) + 1;
        if (span_sx <= 0 || span_sy <= 0 || span_dx <= 0 || span_dy <= 0)
            return r;
        if (ox >= span_dx || oy >= span_dy)
            return r;
        // operands are non-negative here, so / truncates toward zero
        sx = ox * span_sx / span_dx + int'(zoom_reg[REG_SRC_LEFT]);
        sy = oy * span_sy / span_dy + int'(zoom_reg[REG_SRC_TOP]);
        ax = ox + int'(zoom_reg[REG_DST_LEFT]);
        ay = oy + int'(zoom_reg[REG_DST_TOP]);
        if (sx < 0 || sx >= DEF_SRC_WIDTH || sy < 0 || sy >= DEF_SRC_HEIGHT)
            return r;
        if (ax < 0 || ax >= DEF_DST_WIDTH || ay < 0 || ay >= DEF_DST_HEIGHT)
            return r;
        lin            = sy * DEF_SRC_WIDTH + sx;
        r.src_offset   = lin[ADDR_W-1:0];
        lin            = ay * DEF_DST_WIDTH + ax;
        r.dst_offset   = lin[ADDR_W-1:0];
        r.write_enable = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input int value);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = value[CFG_DATA_W-1:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pixel(input int x, input int y, input logic literal,
                                      input out_item_t want);
        stim_row_t row;
        row             = '0;
        row.kind        = ROW_PIXEL;
        row.px.offset_x = x[OFS_W-1:0];
        row.px.offset_y = y[OFS_W-1:0];
        row.literal     = literal;
        row.want        = want;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Signals change only right after a rising edge. valid/start drop
    // on a gap or when a channel idles; back-to-back transfers keep them high.
    // ------------------------------------------------------------------------
    task automatic write_zoom_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        // writes past the last register are dropped by the block
        if (idx < NUM_ZOOM_REGS)
            zoom_reg[idx] = data;
    endtask

    task automatic send_pixel(input in_item_t px, input logic literal,
                              input out_item_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= px;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_pixels.push_back(literal ? want : map_pixel(px));
    endtask

    // Quiesce both channels and wait for every outstanding result.
    task automatic drain_results();
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    // lo in [lo_min, hi_max], hi in [lo, min(lo + max_len, hi_max)]
    function automatic void pick_span(input int lo_min, input int hi_max,
                                      input int max_len, output int lo, output int hi);
        int room;
        lo   = lo_min + int'($urandom_range(0, hi_max - lo_min));
        room = hi_max - lo;
        if (room > max_len)
            room = max_len;
        hi = lo + int'($urandom_range(0, room));
    endfunction

    // Mostly offsets inside the destination span, some on its border,
    // the rest any 12-bit value.
    function automatic logic [OFS_W-1:0] pick_offset(input int span);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (span > (1 << OFS_W)) ? (1 << OFS_W) - 1 : span - 1;
        if (span <= 0 || roll < 12)
            return OFS_W'($urandom_range(0, (1 << OFS_W) - 1));
        if (roll < 16)
            return OFS_W'(top);
        if (roll < 20)
            return OFS_W'((top + 1 > (1 << OFS_W) - 1) ? top : top + 1);
        if (roll < 23)
            return '0;
        return OFS_W'($urandom_range(0, top));
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the edge
    // that ends it. Each transfer pops the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result transfer: src_offset %0d dst_offset %0d we %0b",
                       result.src_offset, result.dst_offset, result.write_enable);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (result.src_offset !== want.src_offset)
                begin
                    $error("src_offset: expected %0d, got %0d",
                           want.src_offset, result.src_offset);
                    mismatches++;
                end
                if (result.dst_offset !== want.dst_offset)
                begin
                    $error("dst_offset: expected %0d, got %0d",
                           want.dst_offset, result.dst_offset);
                    mismatches++;
                end
                if (result.write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %0b, got %0b",
                           want.write_enable, result.write_enable);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("nearest_neighbor_zoom_addresser_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int plan [NUM_ZOOM_REGS];
        int lo, hi;
        int sent;
        int phase_len;
        int first;
        int mode;
        int span_dx, span_dy;
        in_item_t px;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (zoom_reg[i])
            zoom_reg[i] = '0;

        // --- directed table ---
        // reset corners are all 0: every span is 1, only (0,0) is inside
        add_pixel(0, 0, 1'b1, {20'd0, 20'd0, 1'b1});
        add_pixel(1, 0, 1'b1, SKIPPED);
        add_pixel(0, 1, 1'b1, SKIPPED);
        add_pixel(4095, 4095, 1'b1, SKIPPED);
        // identity over the whole 1024x1024 frame
        add_write(REG_SRC_LEFT, 0);
        add_write(REG_SRC_TOP, 0);
        add_write(REG_SRC_RIGHT, 1023);
        add_write(REG_SRC_BOTTOM, 1023);
        add_write(REG_DST_LEFT, 0);
        add_write(REG_DST_TOP, 0);
        add_write(REG_DST_RIGHT, 1023);
        add_write(REG_DST_BOTTOM, 1023);
        add_pixel(1023, 1023, 1'b1, {20'hFFFFF, 20'hFFFFF, 1'b1});
        add_pixel(1024, 0, 1'b1, SKIPPED);
        add_pixel(0, 0, 1'b1, {20'd0, 20'd0, 1'b1});
        add_pixel(5, 7, 1'b0, SKIPPED);
        // 4x upscale of a 100x100 source into 400x400 at (100,100)
        add_write(REG_SRC_RIGHT, 99);
        add_write(REG_SRC_BOTTOM, 99);
        add_write(REG_DST_LEFT, 100);
        add_write(REG_DST_TOP, 100);
        add_write(REG_DST_RIGHT, 499);
        add_write(REG_DST_BOTTOM, 499);
        add_pixel(399, 399, 1'b0, SKIPPED);
        add_pixel(3, 2, 1'b0, SKIPPED);
        add_pixel(400, 0, 1'b1, SKIPPED);
        // negative source span, then zero source span
        add_write(REG_SRC_RIGHT, -5);
        add_pixel(0, 0, 1'b1, SKIPPED);
        add_write(REG_SRC_RIGHT, -1);
        add_pixel(0, 0, 1'b1, SKIPPED);
        // source window wider than the frame: both sides fall off it
        add_write(REG_SRC_LEFT, -2048);
        add_write(REG_SRC_RIGHT, 2047);
        add_pixel(0, 0, 1'b1, SKIPPED);
        add_pixel(399, 0, 1'b1, SKIPPED);
        add_pixel(250, 10, 1'b0, SKIPPED);
        // destination window wider than the frame
        add_write(REG_SRC_LEFT, 0);
        add_write(REG_SRC_RIGHT, 99);
        add_write(REG_DST_LEFT, -2048);
        add_write(REG_DST_RIGHT, 2047);
        add_pixel(0, 0, 1'b1, SKIPPED);
        add_pixel(4095, 0, 1'b1, SKIPPED);
        add_pixel(2100, 50, 1'b0, SKIPPED);
        // writes past the last register leave the corners alone
        add_write(CFG_IDX_W'(NUM_ZOOM_REGS), 'h5A5);
        add_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 'hA5A);
        add_pixel(2100, 50, 1'b0, SKIPPED);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_WRITE)
                    drain_results();
                write_zoom_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                if (i > 0 && directed_rows[i-1].kind == ROW_WRITE)
                    cfg_valid <= 1'b0;
                send_pixel(directed_rows[i].px, directed_rows[i].literal,
                           directed_rows[i].want);
            end
        end

        // --- random phases: new rectangles, then a burst of offsets ---
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain_results();
            idle_on = ($urandom_range(0, 3) != 0);
            mode    = $urandom_range(0, 5);
            case (mode)
                0, 1:
                begin
                    // both rectangles inside the frames: mostly enabled
                    pick_span(0, 1023, 1023, plan[REG_SRC_LEFT], plan[REG_SRC_RIGHT]);
                    pick_span(0, 1023, 1023, plan[REG_SRC_TOP], plan[REG_SRC_BOTTOM]);
                    pick_span(0, 1023, 1023, plan[REG_DST_LEFT], plan[REG_DST_RIGHT]);
                    pick_span(0, 1023, 1023, plan[REG_DST_TOP], plan[REG_DST_BOTTOM]);
                end
                2:
                begin
                    // anywhere in the register range, straddling frame borders
                    pick_span(-2048, 2047, 4095, plan[REG_SRC_LEFT], plan[REG_SRC_RIGHT]);
                    pick_span(-2048, 2047, 4095, plan[REG_SRC_TOP], plan[REG_SRC_BOTTOM]);
                    pick_span(-2048, 2047, 4095, plan[REG_DST_LEFT], plan[REG_DST_RIGHT]);
                    pick_span(-2048, 2047, 4095, plan[REG_DST_TOP], plan[REG_DST_BOTTOM]);
                end
                3:
                begin
                    // corner values only
                    foreach (plan[i])
                    begin
                        case ($urandom_range(0, 6))
                            0:       plan[i] = -2048;
                            1:       plan[i] = -1;
                            2:       plan[i] = 0;
                            3:       plan[i] = 1;
                            4:       plan[i] = 1023;
                            5:       plan[i] = 1024;
                            default: plan[i] = 2047;
                        endcase
                    end
                end
                4:
                begin
                    // raw register noise, often a non-positive span
                    foreach (plan[i])
                        plan[i] = int'($urandom_range(0, 4095)) - 2048;
                end
                default:
                begin
                    // tiny windows anywhere in the frame or just off its origin: border offsets matter
                    pick_span(-20, 1023, 15, plan[REG_SRC_LEFT], plan[REG_SRC_RIGHT]);
                    pick_span(-20, 1023, 15, plan[REG_SRC_TOP], plan[REG_SRC_BOTTOM]);
                    pick_span(-20, 1023, 15, plan[REG_DST_LEFT], plan[REG_DST_RIGHT]);
                    pick_span(-20, 1023, 15, plan[REG_DST_TOP], plan[REG_DST_BOTTOM]);
                end
            endcase

            if ($urandom_range(0, 3) == 0)
                write_zoom_reg(CFG_IDX_W'($urandom_range(NUM_ZOOM_REGS, (1 << CFG_IDX_W) - 1)),
                               CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
            // rotate the write order so no register is always first
            first = $urandom_range(0, NUM_ZOOM_REGS - 1);
            for (int k = 0; k < NUM_ZOOM_REGS; k++)
            begin
                lo = (first + k) % NUM_ZOOM_REGS;
                hi = plan[lo];
                write_zoom_reg(lo[CFG_IDX_W-1:0], hi[CFG_DATA_W-1:0]);
            end
            cfg_valid <= 1'b0;

            span_dx   = int'(zoom_reg[REG_DST_RIGHT]) - int'(zoom_reg[REG_DST_LEFT]) + 1;
            span_dy   = int'(zoom_reg[REG_DST_BOTTOM]) - int'(zoom_reg[REG_DST_TOP]) + 1;
            phase_len = $urandom_range(40, 110);
            for (int n = 0; n < phase_len; n++)
            begin
                px.offset_x = pick_offset(span_dx);
                px.offset_y = pick_offset(span_dy);
                send_pixel(px, 1'b0, SKIPPED);
                sent++;
            end
        end

        // --- wind down: let the pipeline empty, then a few spare cycles ---
        drain_results();
        repeat (ZM_LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("nearest_neighbor_zoom_addresser_top regression: pass");
        else
            $display("nearest_neighbor_zoom_addresser_top regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/nnza_pkg.sv
sv/nearest_neighbor_zoom_addresser_top.sv
sv/nnza_chk.sv
test/tb_top.sv
